[rtl/core/drf_pkg.sv]
// Package for the delta regression filter: sequencer states, configuration
// register indexes and the fixed-point constants of the datapath.
// Depends on nothing; used by delta_regression_filter_top.
package drf_pkg;

    // Sequencer states of the shared arithmetic unit.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_PRIOR,
        S_RD_LATER,
        S_TERM,
        S_DIV,
        S_DIV_END,
        S_ACC_TERM,
        S_ACC_NUM,
        S_RESULT
    } state_t;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 4;
    localparam int HALF_WINDOW_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_WINDOW      = 3'd0,
        CFG_ABS_OUTPUT       = 3'd1,
        CFG_HALF_WAVE_RECT   = 3'd2,
        CFG_ONLY_IN_SEGMENTS = 3'd3,
        CFG_RELATIVE_DELTA   = 3'd4
    } cfg_index_t;

    localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RESET = 4'd2;

    // Q16.16 fraction bits, and the magnitude cap of a relative term (2^50).
    localparam int FRAC_BITS = 16;
    localparam int CAP_BITS  = 50;

endpackage

[rtl/core/delta_regression_filter_top.sv]
// Each item runs over P = max(W,1) pairs. The divider is NUMW bits wide (58 by default)
// and serves each relative term with a non-zero prior, and the final division when W > 0
// and some pair was counted.
// Pacing: a new item is taken only once the block is idle again; the single restoring
// divider, one quotient bit per cycle, and the one-read-port line memory set the pace.
// Reset: asynchronous, active low; clears the sequencer, fill count and control registers;
// the configuration registers take their defaults, the payload registers are not reset.
// Delta regression filter top level: circular sample line, shared divider and sequencer.
// Depends on drf_pkg.
module delta_regression_filter_top #(
    parameter int MAX_HALF_WINDOW = 8,
    parameter int SAMPLE_WIDTH    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
    input  logic                                 sample_missing,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       delta_value,
    output logic                                 window_primed,
    input  logic                                 cfg_write,
    input  logic [drf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [drf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW         = SAMPLE_WIDTH;
    localparam int M          = MAX_HALF_WINDOW;
    localparam int LINE_DEPTH = 2 * M + 1;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int FW         = $clog2(LINE_DEPTH + 1);
    localparam int IW         = $clog2(M + 1);
    localparam int TW         = (SW + 1 > drf_pkg::CAP_BITS + 2) ? SW + 1
                                                                 : drf_pkg::CAP_BITS + 2;
    localparam int NW         = TW + $clog2(M * (M + 1) / 2 + 1);
    localparam int DEN_MAX    = M * (M + 1) * (2 * M + 1) / 3;
    localparam int DENW       = $clog2(DEN_MAX + 1);
    localparam int DSW        = (SW > DENW) ? SW : DENW;
    localparam int RELW       = SW + 1 + drf_pkg::FRAC_BITS;
    localparam int NUMW       = (RELW > NW) ? RELW : NW;
    localparam int CW         = $clog2(NUMW);
    localparam int RW         = NW + 1;

    localparam logic [NUMW-1:0] CAP_VALUE = NUMW'(1) << drf_pkg::CAP_BITS;
    localparam logic signed [RW:0] SAT_MAX = {{(RW - SW + 2){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [RW:0] SAT_MIN = {{(RW - SW + 2){1'b1}}, {(SW - 1){1'b0}}};

    // Configuration registers.
    logic [drf_pkg::HALF_WINDOW_W-1:0] half_window_reg;
    logic abs_output_reg, half_wave_rect_reg, only_in_segments_reg, relative_delta_reg;

    // Control state.
    drf_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [IW-1:0]  w_reg, w_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           div_final_reg, div_final_next;
    logic           out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [SW:0]              line_mem [LINE_DEPTH];
    logic [SW:0]              rd_data_reg;
    logic                     rd_zero_reg;
    logic signed [SW-1:0]     prior_reg, prior_next;
    logic                     prior_miss_reg, prior_miss_next;
    logic signed [TW-1:0]     term_reg, term_next;
    logic                     pair_ok_reg, pair_ok_next;
    logic signed [NW-1:0]     partial_reg, partial_next;
    logic signed [NW-1:0]     num_reg, num_next;
    logic [DENW-1:0]          den_reg, den_next;
    logic [DSW-1:0]           div_rem_reg, div_rem_next;
    logic [NUMW-1:0]          div_quo_reg, div_quo_next;
    logic [DSW-1:0]           div_den_reg, div_den_next;
    logic                     neg_reg, neg_next;
    logic signed [RW-1:0]     res_reg, res_next;
    logic                     primed_reg, primed_next;
    logic signed [SW-1:0]     delta_value_reg, delta_value_next;
    logic                     window_primed_reg, window_primed_next;

    // Combinational helpers.
    logic                     accept;
    logic [AW-1:0]            wp_inc;
    logic [IW-1:0]            w_eff;
    logic [FW-1:0]            fill_inc;
    logic [FW-1:0]            prime_level;
    logic [AW-1:0]            rd_index, rd_addr;
    logic signed [SW-1:0]     later_val;
    logic                     later_miss;
    logic signed [SW:0]       diff;
    logic [SW:0]              dmag;
    logic [SW-1:0]            pmag;
    logic [DSW:0]             div_shift;
    logic [DSW+1:0]           div_trial;
    logic [NUMW-1:0]          q_capped;
    logic [TW-1:0]            term_mag;
    logic [2*IW-1:0]          i_sq;
    logic signed [NW-1:0]     num_sum;
    logic [NW-1:0]            num_mag;
    logic signed [RW:0]       res_ext, res_adj;

    assign accept        = in_valid && in_ready;
    assign in_ready      = (state_reg == drf_pkg::S_IDLE);
    assign out_valid     = out_valid_reg;
    assign delta_value   = delta_value_reg;
    assign window_primed = window_primed_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg      <= drf_pkg::HALF_WINDOW_RESET;
            abs_output_reg       <= 1'b0;
            half_wave_rect_reg   <= 1'b0;
            only_in_segments_reg <= 1'b0;
            relative_delta_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                drf_pkg::CFG_HALF_WINDOW:      half_window_reg      <= cfg_data;
                drf_pkg::CFG_ABS_OUTPUT:       abs_output_reg       <= cfg_data[0];
                drf_pkg::CFG_HALF_WAVE_RECT:   half_wave_rect_reg   <= cfg_data[0];
                drf_pkg::CFG_ONLY_IN_SEGMENTS: only_in_segments_reg <= cfg_data[0];
                drf_pkg::CFG_RELATIVE_DELTA:   relative_delta_reg   <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // Sample line: newest entry at wp_reg; line position k sits k entries behind it.
    always_comb
    begin
        wp_inc   = (wp_reg == AW'(LINE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        fill_inc = (fill_reg == FW'(LINE_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        w_eff    = (int'(half_window_reg) > M) ? IW'(M) : IW'(half_window_reg);
        prime_level = (w_eff == '0) ? FW'(2) : FW'({w_eff, 1'b1});

        if (state_reg == drf_pkg::S_RD_LATER)
        begin
            rd_index = (w_reg == '0) ? '0 : AW'(w_reg) - AW'(i_reg);
        end
        else
        begin
            rd_index = AW'(w_reg) + AW'(i_reg);
        end

        if (wp_reg >= rd_index)
        begin
            rd_addr = wp_reg - rd_index;
        end
        else
        begin
            rd_addr = AW'({1'b0, wp_reg} + (AW + 1)'(LINE_DEPTH) - {1'b0, rd_index});
        end
    end

    // Positions not yet written since reset read as zero and not missing.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[wp_inc] <= {sample_missing, sample_value};
        end
        rd_data_reg <= line_mem[rd_addr];
        rd_zero_reg <= (FW'(rd_index) >= fill_reg);
    end

    // Datapath helpers.
    always_comb
    begin
        later_val  = rd_zero_reg ? '0 : rd_data_reg[SW-1:0];
        later_miss = !rd_zero_reg && rd_data_reg[SW];
        diff       = {later_val[SW-1], later_val} - {prior_reg[SW-1], prior_reg};
        dmag       = diff[SW] ? -diff : diff;
        pmag       = prior_reg[SW-1] ? -prior_reg : prior_reg;

        div_shift  = {div_rem_reg, div_quo_reg[NUMW-1]};
        div_trial  = {1'b0, div_shift} - {2'b0, div_den_reg};

        q_capped   = (div_quo_reg > CAP_VALUE) ? CAP_VALUE : div_quo_reg;
        term_mag   = TW'(q_capped);
        i_sq       = i_reg * i_reg;

        num_sum    = num_reg + partial_reg;
        num_mag    = num_sum[NW-1] ? -num_sum : num_sum;

        res_ext    = (RW + 1)'(res_reg);
        if (half_wave_rect_reg)
        begin
            res_adj = res_ext[RW] ? '0 : res_ext;
        end
        else if (abs_output_reg)
        begin
            res_adj = res_ext[RW] ? -res_ext : res_ext;
        end
        else
        begin
            res_adj = res_ext;
        end
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next         = state_reg;
        wp_next            = wp_reg;
        fill_next          = fill_reg;
        w_next             = w_reg;
        i_next             = i_reg;
        cnt_next           = cnt_reg;
        div_final_next     = div_final_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        prior_next         = prior_reg;
        prior_miss_next    = prior_miss_reg;
        term_next          = term_reg;
        pair_ok_next       = pair_ok_reg;
        partial_next       = partial_reg;
        num_next           = num_reg;
        den_next           = den_reg;
        div_rem_next       = div_rem_reg;
        div_quo_next       = div_quo_reg;
        div_den_next       = div_den_reg;
        neg_next           = neg_reg;
        res_next           = res_reg;
        primed_next        = primed_reg;
        delta_value_next   = delta_value_reg;
        window_primed_next = window_primed_reg;

        unique case (state_reg)
            drf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    wp_next      = wp_inc;
                    fill_next    = fill_inc;
                    w_next       = w_eff;
                    i_next       = (w_eff == '0) ? IW'(1) : w_eff;
                    primed_next  = (fill_inc >= prime_level);
                    partial_next = '0;
                    num_next     = '0;
                    den_next     = '0;
                    state_next   = drf_pkg::S_RD_PRIOR;
                end
            end

            drf_pkg::S_RD_PRIOR:
            begin
                state_next = drf_pkg::S_RD_LATER;
            end

            drf_pkg::S_RD_LATER:
            begin
                prior_next      = rd_zero_reg ? '0 : rd_data_reg[SW-1:0];
                prior_miss_next = !rd_zero_reg && rd_data_reg[SW];
                state_next      = drf_pkg::S_TERM;
            end

            drf_pkg::S_TERM:
            begin
                if (only_in_segments_reg && (prior_miss_reg || later_miss))
                begin
                    term_next    = '0;
                    pair_ok_next = 1'b0;
                    state_next   = drf_pkg::S_ACC_TERM;
                end
                else if (!relative_delta_reg)
                begin
                    term_next    = TW'(diff);
                    pair_ok_next = 1'b1;
                    state_next   = drf_pkg::S_ACC_TERM;
                end
                else if (prior_reg == '0)
                begin
                    term_next    = '0;
                    pair_ok_next = 1'b1;
                    state_next   = drf_pkg::S_ACC_TERM;
                end
                else
                begin
                    // Relative term: (|diff| << 16) / |prior| on the shared divider.
                    pair_ok_next   = 1'b1;
                    neg_next       = diff[SW];
                    div_rem_next   = '0;
                    div_quo_next   = NUMW'({dmag, {drf_pkg::FRAC_BITS{1'b0}}});
                    div_den_next   = DSW'(pmag);
                    div_final_next = 1'b0;
                    cnt_next       = '0;
                    state_next     = drf_pkg::S_DIV;
                end
            end

            drf_pkg::S_DIV:
            begin
                if (!div_trial[DSW+1])
                begin
                    div_rem_next = div_trial[DSW-1:0];
                end
                else
                begin
                    div_rem_next = div_shift[DSW-1:0];
                end
                div_quo_next = {div_quo_reg[NUMW-2:0], ~div_trial[DSW+1]};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUMW - 1))
                begin
                    state_next = drf_pkg::S_DIV_END;
                end
            end

            drf_pkg::S_DIV_END:
            begin
                if (div_final_reg)
                begin
                    res_next   = neg_reg ? -RW'(div_quo_reg) : RW'(div_quo_reg);
                    state_next = drf_pkg::S_RESULT;
                end
                else
                begin
                    term_next  = neg_reg ? -term_mag : term_mag;
                    state_next = drf_pkg::S_ACC_TERM;
                end
            end

            drf_pkg::S_ACC_TERM:
            begin
                // Weights come from running the pairs from the outside in:
                // the running sum of terms is added once per remaining pair.
                partial_next = partial_reg + NW'(term_reg);
                if (pair_ok_reg)
                begin
                    den_next = den_reg + DENW'({i_sq, 1'b0});
                end
                state_next = drf_pkg::S_ACC_NUM;
            end

            drf_pkg::S_ACC_NUM:
            begin
                num_next = num_sum;
                if (i_reg != IW'(1))
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = drf_pkg::S_RD_PRIOR;
                end
                else if (w_reg == '0)
                begin
                    res_next   = RW'(partial_reg);
                    state_next = drf_pkg::S_RESULT;
                end
                else if (den_reg == '0)
                begin
                    res_next   = '0;
                    state_next = drf_pkg::S_RESULT;
                end
                else
                begin
                    neg_next       = num_sum[NW-1];
                    div_rem_next   = '0;
                    div_quo_next   = NUMW'(num_mag);
                    div_den_next   = DSW'(den_reg);
                    div_final_next = 1'b1;
                    cnt_next       = '0;
                    state_next     = drf_pkg::S_DIV;
                end
            end

            drf_pkg::S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (res_adj > SAT_MAX)
                    begin
                        delta_value_next = SAT_MAX[SW-1:0];
                    end
                    else if (res_adj < SAT_MIN)
                    begin
                        delta_value_next = SAT_MIN[SW-1:0];
                    end
                    else
                    begin
                        delta_value_next = res_adj[SW-1:0];
                    end
                    window_primed_next = primed_reg;
                    state_next         = drf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = drf_pkg::S_IDLE;
            end
        endcase
    end

    // State register and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drf_pkg::S_IDLE;
            wp_reg        <= AW'(LINE_DEPTH - 1);
            fill_reg      <= '0;
            w_reg         <= '0;
            i_reg         <= IW'(1);
            cnt_reg       <= '0;
            div_final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            w_reg         <= w_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            div_final_reg <= div_final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prior_reg         <= prior_next;
        prior_miss_reg    <= prior_miss_next;
        term_reg          <= term_next;
        pair_ok_reg       <= pair_ok_next;
        partial_reg       <= partial_next;
        num_reg           <= num_next;
        den_reg           <= den_next;
        div_rem_reg       <= div_rem_next;
        div_quo_reg       <= div_quo_next;
        div_den_reg       <= div_den_next;
        neg_reg           <= neg_next;
        res_reg           <= res_next;
        primed_reg        <= primed_next;
        delta_value_reg   <= delta_value_next;
        window_primed_reg <= window_primed_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready in the cycle after taking an item");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(LINE_DEPTH))
        else $error("fill count beyond the line depth");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drf_pkg::S_DIV |-> div_rem_reg < div_den_reg)
        else $error("divider remainder not below the divisor");

    a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != drf_pkg::S_IDLE |-> (i_reg != '0) &&
            ((i_reg <= w_reg) || (i_reg == IW'(1))))
        else $error("pair index outside the half window");
`endif

endmodule
